// ----- rtl/svse_pkg.sv -----
// Shared constants, types and helpers of the shadow volume silhouette emitter.
// Depends on nothing; every other file but svse_ram imports it.
package svse_pkg;

	localparam int MAX_FACES = 4096;
	localparam int FACE_AW   = $clog2(MAX_FACES);
	localparam int FACE_W    = 12;
	localparam int VERT_W    = 15;
	localparam int IDX_W     = 16;
	localparam int PLANE_W   = 18;
	localparam int FIX_W     = 32;
	localparam int OFF_W     = 16;
	localparam int PROD_W    = PLANE_W + FIX_W;
	localparam int SUM3_W    = PROD_W + 2;
	localparam int DOT_W     = 2 * FIX_W;
	localparam int CFG_AW    = 5;
	localparam int CFG_DW    = 32;

	localparam logic CMD_FACE = 1'b0;
	localparam logic CMD_EDGE = 1'b1;

	localparam logic [2:0] REG_LIGHT_X = 3'd0;
	localparam logic [2:0] REG_LIGHT_Y = 3'd1;
	localparam logic [2:0] REG_LIGHT_Z = 3'd2;
	localparam logic [2:0] REG_LIGHT_W = 3'd3;
	localparam logic [2:0] REG_VOFFSET = 3'd4;

	localparam logic [FIX_W-1:0] LIGHT_W_RESET = 32'h0001_0000;

	typedef struct packed {
		logic signed [FIX_W-1:0] light_x;
		logic signed [FIX_W-1:0] light_y;
		logic signed [FIX_W-1:0] light_z;
		logic signed [FIX_W-1:0] light_w;
		logic [OFF_W-1:0]        vertex_offset;
	} cfg_t;

	// One item handed to the index sequencer.
	typedef struct packed {
		logic              quad;
		logic              sel;
		logic [VERT_W-1:0] v0;
		logic [VERT_W-1:0] v1;
		logic [VERT_W-1:0] v2;
	} em_item_t;

	function automatic logic [FACE_AW-1:0] face_addr(input logic [FACE_W-1:0] f);
		return FACE_AW'(f);
	endfunction

	function automatic logic face_ok(input logic [FACE_W-1:0] f);
		return 33'(f) < 33'(MAX_FACES);
	endfunction

endpackage

// ----- rtl/svse_if.sv -----
// Request channels of the silhouette emitter: face/edge items in, indices out.
// Depends on svse_pkg.
interface svse_in_if;
	import svse_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [FACE_W-1:0]         face_index;
	logic signed [PLANE_W-1:0] plane_a;
	logic signed [PLANE_W-1:0] plane_b;
	logic signed [PLANE_W-1:0] plane_c;
	logic signed [FIX_W-1:0]   plane_d;
	logic [VERT_W-1:0]         vert_a;
	logic [VERT_W-1:0]         vert_b;
	logic [VERT_W-1:0]         vert_c;
	logic [FACE_W-1:0]         face_first;
	logic [FACE_W-1:0]         face_second;

	modport source (output valid, cmd, face_index, plane_a, plane_b, plane_c, plane_d,
		vert_a, vert_b, vert_c, face_first, face_second, input ready);
	modport sink (input valid, cmd, face_index, plane_a, plane_b, plane_c, plane_d,
		vert_a, vert_b, vert_c, face_first, face_second, output ready);
endinterface

interface svse_out_if;
	import svse_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] out_index;
	logic             is_quad;
	logic             out_last;

	modport source (output valid, out_index, is_quad, out_last, input ready);
	modport sink (input valid, out_index, is_quad, out_last, output ready);
endinterface

// ----- rtl/shadow_volume_silhouette_emit.sv -----
// Shadow volume silhouette emitter. Face items go through a three-stage plane
// test (products, partial sum, full sum and sign) and write a front-facing flag
// into a 1-bit face memory; edge items read both adjacent flags from that memory
// at acceptance. A face yields three triangle indices and a silhouette edge four
// quad indices, one per cycle on the single result port while result.ready is
// high; the sequencer takes the next item as its last index is taken. Edges that
// emit nothing pass at one per cycle unless a later stage is stalled. An edge
// item waits while any face item is still in the three plane stages. Indices are
// registered in the sequencer after the item has passed the plane stages.
// Depends on svse_pkg, svse_if, svse_ram, svse_cfg and svse_emit.
module shadow_volume_silhouette_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [svse_pkg::CFG_AW-1:0] paddr,
	input  logic [svse_pkg::CFG_DW-1:0] pwdata,
	output logic [svse_pkg::CFG_DW-1:0] prdata,
	output logic                        pready,
	svse_in_if.sink                     item,
	svse_out_if.source                  result
);
	import svse_pkg::*;

	cfg_t cfg;

	logic acc, adv1, adv2, adv3, face_pending;

	logic                     v_s1, edge_s1, fok_s1, fok0_s1, fok1_s1;
	logic [FACE_AW-1:0]       fa_s1;
	logic [VERT_W-1:0]        va_s1, vb_s1, vc_s1;
	logic signed [PROD_W-1:0] prod_a_s1, prod_b_s1, prod_c_s1;
	logic signed [DOT_W-1:0]  prod_d_s1;

	logic                     v_s2, edge_s2, fok_s2, f0_s2, f1_s2;
	logic [FACE_AW-1:0]       fa_s2;
	logic [VERT_W-1:0]        va_s2, vb_s2, vc_s2;
	logic signed [SUM3_W-1:0] sum3_s2;
	logic signed [DOT_W-1:0]  prod_d_s2;
	logic signed [DOT_W-1:0]  dot_sum;

	logic                     v_s3, edge_s3, fok_s3, sel_s3, drop_s3;
	logic [FACE_AW-1:0]       fa_s3;
	logic [VERT_W-1:0]        va_s3, vb_s3, vc_s3;

	logic     ram_we, rd0, rd1;
	logic     em_valid, em_ready;
	em_item_t em_item;

	svse_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign face_pending = (v_s1 && !edge_s1) || (v_s2 && !edge_s2) || (v_s3 && !edge_s3);
	assign adv3 = !v_s3 || drop_s3 || em_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign item.ready = adv1 && !((item.cmd == CMD_EDGE) && face_pending);
	assign acc = item.valid && item.ready;

	svse_ram #(
		.WIDTH (1),
		.DEPTH (MAX_FACES)
	) u_flags (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (fa_s3),
		.wdata  (sel_s3),
		.re     (acc),
		.raddr0 (face_addr(item.face_first)),
		.raddr1 (face_addr(item.face_second)),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	assign ram_we = v_s3 && !edge_s3 && fok_s3 && adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= acc;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (acc) begin
			edge_s1   <= (item.cmd == CMD_EDGE);
			fok_s1    <= face_ok(item.face_index);
			fok0_s1   <= face_ok(item.face_first);
			fok1_s1   <= face_ok(item.face_second);
			fa_s1     <= face_addr(item.face_index);
			va_s1     <= item.vert_a;
			vb_s1     <= item.vert_b;
			vc_s1     <= item.vert_c;
			prod_a_s1 <= item.plane_a * cfg.light_x;
			prod_b_s1 <= item.plane_b * cfg.light_y;
			prod_c_s1 <= item.plane_c * cfg.light_z;
			prod_d_s1 <= item.plane_d * cfg.light_w;
		end
	end

	// partial sum, capture edge flags
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			edge_s2   <= edge_s1;
			fok_s2    <= fok_s1;
			fa_s2     <= fa_s1;
			va_s2     <= va_s1;
			vb_s2     <= vb_s1;
			vc_s2     <= vc_s1;
			f0_s2     <= rd0 && fok0_s1;
			f1_s2     <= rd1 && fok1_s1;
			sum3_s2   <= SUM3_W'(prod_a_s1) + SUM3_W'(prod_b_s1) + SUM3_W'(prod_c_s1);
			prod_d_s2 <= prod_d_s1;
		end
	end

	assign dot_sum = DOT_W'(sum3_s2) + prod_d_s2;

	// sign test
	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			edge_s3 <= edge_s2;
			fok_s3  <= fok_s2;
			fa_s3   <= fa_s2;
			va_s3   <= va_s2;
			vb_s3   <= vb_s2;
			vc_s3   <= vc_s2;
			sel_s3  <= edge_s2 ? f1_s2 : (dot_sum > 64'sd0);
			drop_s3 <= edge_s2 && (f0_s2 == f1_s2);
		end
	end

	assign em_valid     = v_s3 && !drop_s3;
	assign em_item.quad = edge_s3;
	assign em_item.sel  = sel_s3;
	assign em_item.v0   = va_s3;
	assign em_item.v1   = vb_s3;
	assign em_item.v2   = vc_s3;

	svse_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.offset     (cfg.vertex_offset),
		.load_valid (em_valid),
		.load_item  (em_item),
		.load_ready (em_ready),
		.result     (result)
	);

`ifndef SYNTHESIS
	a_edge_after_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && item.cmd == CMD_EDGE) |-> !face_pending)
		else $error("edge request accepted while a face flag write is pending");

	a_flag_write_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !(acc && item.cmd == CMD_EDGE))
		else $error("face flag write collides with an edge flag read");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && result.out_last && !em_valid) |=> !result.valid)
		else $error("result still valid after last index with nothing loaded");
`endif
endmodule

// ----- rtl/svse_ram.sv -----
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module svse_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end
endmodule

// ----- rtl/svse_cfg.sv -----
// APB register file: light position, light w and vertex offset.
// Depends on svse_pkg.
module svse_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [svse_pkg::CFG_AW-1:0] paddr,
	input  logic [svse_pkg::CFG_DW-1:0] pwdata,
	output logic [svse_pkg::CFG_DW-1:0] prdata,
	output logic                        pready,
	output svse_pkg::cfg_t              cfg
);
	import svse_pkg::*;

	logic [2:0] reg_sel;
	logic       wr;

	assign reg_sel = paddr[4:2];
	assign wr      = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.light_x       <= '0;
			cfg.light_y       <= '0;
			cfg.light_z       <= '0;
			cfg.light_w       <= LIGHT_W_RESET;
			cfg.vertex_offset <= '0;
		end else if (wr) begin
			case (reg_sel)
				REG_LIGHT_X: cfg.light_x       <= pwdata;
				REG_LIGHT_Y: cfg.light_y       <= pwdata;
				REG_LIGHT_Z: cfg.light_z       <= pwdata;
				REG_LIGHT_W: cfg.light_w       <= pwdata;
				REG_VOFFSET: cfg.vertex_offset <= pwdata[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_LIGHT_X: prdata = cfg.light_x;
			REG_LIGHT_Y: prdata = cfg.light_y;
			REG_LIGHT_Z: prdata = cfg.light_z;
			REG_LIGHT_W: prdata = cfg.light_w;
			REG_VOFFSET: prdata = CFG_DW'(cfg.vertex_offset);
			default:     prdata = '0;
		endcase
	end
endmodule

// ----- rtl/svse_emit.sv -----
// Index sequencer: turns one face or silhouette edge into three or four indices.
// Depends on svse_pkg and svse_if.
module svse_emit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [svse_pkg::OFF_W-1:0] offset,
	input  logic                       load_valid,
	input  svse_pkg::em_item_t         load_item,
	output logic                       load_ready,
	svse_out_if.source                 result
);
	import svse_pkg::*;

	logic             busy_q;
	logic [1:0]       cnt_q;
	logic [1:0]       last_q;
	logic             quad_q;
	logic [IDX_W-1:0] idx_q [4];
	logic [IDX_W-1:0] nxt [4];
	logic [IDX_W-1:0] add;
	logic [VERT_W-1:0] p;
	logic [VERT_W-1:0] q;
	logic             at_last;
	logic             load;

	assign at_last    = (cnt_q == last_q);
	assign load_ready = !busy_q || (result.ready && at_last);
	assign load       = load_valid && load_ready;

	always_comb begin
		add = (load_item.sel) ? '0 : offset;
		p   = load_item.sel ? load_item.v0 : load_item.v1;
		q   = load_item.sel ? load_item.v1 : load_item.v0;
		if (load_item.quad) begin
			nxt[0] = IDX_W'(p);
			nxt[1] = IDX_W'(q);
			nxt[2] = IDX_W'(q) + offset;
			nxt[3] = IDX_W'(p) + offset;
		end else begin
			nxt[0] = IDX_W'(load_item.v0) + add;
			nxt[1] = IDX_W'(load_item.v1) + add;
			nxt[2] = IDX_W'(load_item.v2) + add;
			nxt[3] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && result.ready) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			idx_q  <= nxt;
			quad_q <= load_item.quad;
			last_q <= load_item.quad ? 2'd3 : 2'd2;
		end
	end

	assign result.valid     = busy_q;
	assign result.out_index = idx_q[cnt_q];
	assign result.is_quad   = quad_q;
	assign result.out_last  = at_last;
endmodule
